// ===== hw/rtl/coapp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coapp_pkg
// shared types and codes of the coap message parser
// ----------------------------------------------------------------------------
package coapp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TOKEN   = 3'd1,
        PH_OPTHDR  = 3'd2,
        PH_OPTEXT  = 3'd3,
        PH_VALUE   = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_DISCARD = 3'd6
    } t_phase;

    typedef enum logic [3:0] {
        K_HDR_BYTE  = 4'd0,
        K_HDR_DONE  = 4'd1,
        K_TOKEN     = 4'd2,
        K_OPT_HDR   = 4'd3,
        K_OPT_START = 4'd4,
        K_VALUE     = 4'd5,
        K_MARKER    = 4'd6,
        K_PAYLOAD   = 4'd7,
        K_DISCARD   = 4'd8,
        K_END       = 4'd9
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_FORMAT   = 2'd2,
        ST_IGNORED  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        EXT_NONE = 2'd0,
        EXT_ONE  = 2'd1,
        EXT_TWO  = 2'd2
    } t_ext_mode;

    localparam logic [7:0]  MARKER_BYTE = 8'hFF;
    localparam logic [3:0]  NIB_EXT1    = 4'd13;
    localparam logic [3:0]  NIB_EXT2    = 4'd14;
    localparam logic [3:0]  NIB_RSVD    = 4'd15;
    localparam logic [3:0]  MAX_TKL     = 4'd8;
    localparam logic [1:0]  COAP_VER    = 2'd1;
    localparam logic [15:0] EXT1_BIAS   = 16'd13;
    localparam logic [15:0] EXT2_BIAS   = 16'd269;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  byte_value;
        logic [1:0]  message_type;
        logic [3:0]  token_length;
        logic [2:0]  code_major;
        logic [4:0]  code_minor;
        logic [15:0] message_id;
        logic [15:0] opt_number;
        logic [15:0] option_length;
        t_status     status;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic valid;
        logic two;
    } t_push;

endpackage

// ===== hw/rtl/coapp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coapp_if
// byte input channel and result output channel of the coap message parser
// ----------------------------------------------------------------------------
interface coapp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface coapp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [7:0]  byte_value;
    logic [1:0]  message_type;
    logic [3:0]  token_length;
    logic [2:0]  code_major;
    logic [4:0]  code_minor;
    logic [15:0] message_id;
    logic [15:0] opt_number;
    logic [15:0] option_length;
    logic [1:0]  status;
    logic        last_of_run;

    modport source (
        output valid, input ready,
        output kind, output byte_value, output message_type, output token_length,
        output code_major, output code_minor, output message_id,
        output opt_number, output option_length, output status, output last_of_run
    );
    modport sink (
        input valid, output ready,
        input kind, input byte_value, input message_type, input token_length,
        input code_major, input code_minor, input message_id,
        input opt_number, input option_length, input status, input last_of_run
    );
endinterface

// ===== hw/rtl/coapp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coapp_parser
// datagram phase tracking and per-byte result generation
// ----------------------------------------------------------------------------
module coapp_parser
    import coapp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output t_push      o_push,
    output t_result    o_res0,
    output t_result    o_res1
);

    t_phase      r_phase,  n_phase;
    logic [1:0]  r_hidx,   n_hidx;
    logic [7:0]  r_first,  n_first;
    logic [7:0]  r_code,   n_code;
    logic [7:0]  r_idhi,   n_idhi;
    logic [3:0]  r_tok,    n_tok;
    logic [15:0] r_prev,   n_prev;
    logic [15:0] r_delta,  n_delta;
    logic [15:0] r_len,    n_len;
    t_ext_mode   r_dmode,  n_dmode;
    t_ext_mode   r_lmode,  n_lmode;
    logic        r_eidx,   n_eidx;
    logic [15:0] r_vrem,   n_vrem;
    t_status     r_err,    n_err;

    always_comb begin
        logic [3:0]  d_nib;
        logic [3:0]  l_nib;
        logic [3:0]  tkl;
        logic        opt_start;
        logic [15:0] num;

        n_phase = r_phase;  n_hidx  = r_hidx;  n_first = r_first; n_code = r_code;
        n_idhi  = r_idhi;   n_tok   = r_tok;   n_prev  = r_prev;  n_delta = r_delta;
        n_len   = r_len;    n_dmode = r_dmode; n_lmode = r_lmode; n_eidx = r_eidx;
        n_vrem  = r_vrem;   n_err   = r_err;
        o_res0      = '0;
        o_res1      = '0;
        o_res1.kind = K_END;
        d_nib     = i_data_byte[7:4];
        l_nib     = i_data_byte[3:0];
        tkl       = r_first[3:0];
        opt_start = 1'b0;
        num       = '0;

        case (r_phase)
            PH_HEADER: begin
                o_res0.kind = K_HDR_BYTE;
                case (r_hidx)
                    2'd0: n_first = i_data_byte;
                    2'd1: n_code  = i_data_byte;
                    2'd2: n_idhi  = i_data_byte;
                    default: begin
                        if (r_first[7:6] != COAP_VER) begin
                            n_err   = ST_IGNORED;
                            n_phase = PH_DISCARD;
                        end else if (tkl > MAX_TKL) begin
                            n_err   = ST_FORMAT;
                            n_phase = PH_DISCARD;
                        end else begin
                            o_res0.kind         = K_HDR_DONE;
                            o_res0.message_type = r_first[5:4];
                            o_res0.token_length = tkl;
                            o_res0.code_major   = r_code[7:5];
                            o_res0.code_minor   = r_code[4:0];
                            o_res0.message_id   = {r_idhi, i_data_byte};
                            n_tok   = tkl;
                            n_phase = (tkl != 4'd0) ? PH_TOKEN : PH_OPTHDR;
                        end
                    end
                endcase
                if (r_hidx != 2'd3) begin
                    n_hidx = 2'(r_hidx + 2'd1);
                end
            end
            PH_TOKEN: begin
                o_res0.kind       = K_TOKEN;
                o_res0.byte_value = i_data_byte;
                n_tok = 4'(r_tok - 4'd1);
                if (n_tok == 4'd0) begin
                    n_phase = PH_OPTHDR;
                end
            end
            PH_OPTHDR: begin
                if (i_data_byte == MARKER_BYTE) begin
                    o_res0.kind = K_MARKER;
                    n_phase     = PH_PAYLOAD;
                end else begin
                    o_res0.kind = K_OPT_HDR;
                    if (d_nib == NIB_RSVD || l_nib == NIB_RSVD) begin
                        n_err   = ST_FORMAT;
                        n_phase = PH_DISCARD;
                    end else begin
                        n_delta = {12'd0, d_nib};
                        n_len   = {12'd0, l_nib};
                        n_dmode = (d_nib == NIB_EXT1) ? EXT_ONE :
                                  (d_nib == NIB_EXT2) ? EXT_TWO : EXT_NONE;
                        n_lmode = (l_nib == NIB_EXT1) ? EXT_ONE :
                                  (l_nib == NIB_EXT2) ? EXT_TWO : EXT_NONE;
                        n_eidx  = 1'b0;
                        if (n_dmode == EXT_NONE && n_lmode == EXT_NONE) begin
                            opt_start = 1'b1;
                        end else begin
                            n_phase = PH_OPTEXT;
                        end
                    end
                end
            end
            PH_OPTEXT: begin
                o_res0.kind = K_OPT_HDR;
                // delta extension first, then length extension
                if (r_dmode != EXT_NONE) begin
                    if (r_dmode == EXT_ONE) begin
                        n_delta = {8'd0, i_data_byte} + EXT1_BIAS;
                        n_dmode = EXT_NONE;
                    end else if (!r_eidx) begin
                        n_delta = {i_data_byte, 8'd0};
                        n_eidx  = 1'b1;
                    end else begin
                        n_delta = 16'(r_delta + {8'd0, i_data_byte} + EXT2_BIAS);
                        n_eidx  = 1'b0;
                        n_dmode = EXT_NONE;
                    end
                end else begin
                    if (r_lmode == EXT_ONE) begin
                        n_len   = {8'd0, i_data_byte} + EXT1_BIAS;
                        n_lmode = EXT_NONE;
                    end else if (!r_eidx) begin
                        n_len   = {i_data_byte, 8'd0};
                        n_eidx  = 1'b1;
                    end else begin
                        n_len   = 16'(r_len + {8'd0, i_data_byte} + EXT2_BIAS);
                        n_eidx  = 1'b0;
                        n_lmode = EXT_NONE;
                    end
                end
                if (n_dmode == EXT_NONE && n_lmode == EXT_NONE) begin
                    opt_start = 1'b1;
                end
            end
            PH_VALUE: begin
                o_res0.kind       = K_VALUE;
                o_res0.byte_value = i_data_byte;
                n_vrem = 16'(r_vrem - 16'd1);
                if (n_vrem == 16'd0) begin
                    n_phase = PH_OPTHDR;
                end
            end
            PH_PAYLOAD: begin
                o_res0.kind       = K_PAYLOAD;
                o_res0.byte_value = i_data_byte;
            end
            default: begin
                o_res0.kind = K_DISCARD;
            end
        endcase

        if (opt_start) begin
            num = 16'(r_prev + n_delta);
            o_res0.kind          = K_OPT_START;
            o_res0.opt_number    = num;
            o_res0.option_length = n_len;
            n_prev  = num;
            n_vrem  = n_len;
            n_phase = (n_len != 16'd0) ? PH_VALUE : PH_OPTHDR;
        end

        if (i_last_byte) begin
            if (n_err != ST_OK) begin
                o_res1.status = n_err;
            end else if (n_phase == PH_OPTHDR || n_phase == PH_PAYLOAD) begin
                o_res1.status = ST_OK;
            end else begin
                o_res1.status = ST_SHORT;
            end
            o_res1.last_of_run = 1'b1;
            n_phase = PH_HEADER;  n_hidx  = '0;       n_first = '0;  n_code = '0;
            n_idhi  = '0;         n_tok   = '0;       n_prev  = '0;  n_delta = '0;
            n_len   = '0;         n_dmode = EXT_NONE; n_lmode = EXT_NONE;
            n_eidx  = 1'b0;       n_vrem  = '0;       n_err   = ST_OK;
        end else begin
            o_res0.last_of_run = 1'b1;
        end

        o_push.valid = i_accept;
        o_push.two   = i_last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_hidx  <= '0;       r_first <= '0; r_code <= '0;
            r_idhi  <= '0;        r_tok   <= '0;       r_prev  <= '0; r_delta <= '0;
            r_len   <= '0;        r_dmode <= EXT_NONE; r_lmode <= EXT_NONE;
            r_eidx  <= 1'b0;      r_vrem  <= '0;       r_err   <= ST_OK;
        end else if (i_accept) begin
            r_phase <= n_phase; r_hidx  <= n_hidx;  r_first <= n_first; r_code <= n_code;
            r_idhi  <= n_idhi;  r_tok   <= n_tok;   r_prev  <= n_prev;  r_delta <= n_delta;
            r_len   <= n_len;   r_dmode <= n_dmode; r_lmode <= n_lmode;
            r_eidx  <= n_eidx;  r_vrem  <= n_vrem;  r_err   <= n_err;
        end
    end

    // an error always parks the parser in the discard phase until the datagram ends
    a_err_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK) |-> (r_phase == PH_DISCARD))
        else $error("error latched outside discard phase");

    // the final byte returns the parser to the header phase
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_byte) |=> (r_phase == PH_HEADER && r_hidx == 2'd0))
        else $error("state not cleared after final byte");

    // extension bytes only while an extension is outstanding
    a_ext_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_OPTEXT) |-> (r_dmode != EXT_NONE || r_lmode != EXT_NONE))
        else $error("extension phase with no extension pending");

endmodule

// ===== hw/rtl/coapp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coapp_queue
// small result queue taking one or two results per cycle, giving one
// ----------------------------------------------------------------------------
module coapp_queue
    import coapp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  t_result i_res0,
    input  t_result i_res1,
    input  logic    i_pop,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_head
);

    localparam logic [QPTR_W:0] DEPTH_C = (QPTR_W + 1)'(QUEUE_DEPTH);

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QPTR_W:0]   r_count, n_count;
    logic              do_pop;
    logic [QPTR_W:0]   push_n;

    assign o_room  = (r_count <= DEPTH_C - (QPTR_W + 1)'(2));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        push_n  = i_push.valid ? (i_push.two ? (QPTR_W + 1)'(2) : (QPTR_W + 1)'(1)) : '0;
        n_wptr  = QPTR_W'(r_wptr + push_n[QPTR_W-1:0]);
        n_rptr  = do_pop ? QPTR_W'(r_rptr + QPTR_W'(1)) : r_rptr;
        n_count = (QPTR_W + 1)'(r_count + push_n - {{QPTR_W{1'b0}}, do_pop});
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_res0;
            if (i_push.two) begin
                r_mem[QPTR_W'(r_wptr + QPTR_W'(1))] <= i_res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> o_room)
        else $error("push without room for two results");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !i_push.valid) |=> (r_count == $past(r_count) - (QPTR_W + 1)'(1)))
        else $error("pop did not drain one entry");

endmodule

// ===== hw/rtl/coap_message_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coap_message_parser
// byte-serial parser of coap datagrams: header, token, options, payload
// ----------------------------------------------------------------------------
// One datagram byte is taken per request on i_byte, with last_byte set on its
// final byte. Each byte gives one role result on o_res; the final byte gives a
// second result of kind end that carries the status, after which the parser
// starts over on a new datagram. A byte is taken in every cycle while the
// four-entry result queue has room for two results, and its results are
// registered in that queue. With o_res always ready the block sustains
// one byte per cycle, and each final byte adds one extra result to drain
// through the single output port of the result queue.
module coap_message_parser
    import coapp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    coapp_in_if.sink           i_byte,
    coapp_out_if.source        o_res
);

    logic    accept;
    logic    room;
    logic    head_valid;
    t_push   push;
    t_result res0;
    t_result res1;
    t_result head;

    // a byte is taken only when both of its possible results fit
    assign i_byte.ready = room;
    assign accept       = i_byte.valid && room;

    // header, token and option decode with all phase state
    coapp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_byte.data_byte),
        .i_last_byte (i_byte.last_byte),
        .o_push      (push),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    // result queue parts the input side from a stalled consumer
    coapp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_pop   (o_res.ready),
        .o_room  (room),
        .o_valid (head_valid),
        .o_head  (head)
    );

    // result fields to the output channel
    assign o_res.valid         = head_valid;
    assign o_res.kind          = head.kind;
    assign o_res.byte_value    = head.byte_value;
    assign o_res.message_type  = head.message_type;
    assign o_res.token_length  = head.token_length;
    assign o_res.code_major    = head.code_major;
    assign o_res.code_minor    = head.code_minor;
    assign o_res.message_id    = head.message_id;
    assign o_res.opt_number    = head.opt_number;
    assign o_res.option_length = head.option_length;
    assign o_res.status        = head.status;
    assign o_res.last_of_run   = head.last_of_run;

    // every byte taken leaves something to deliver next cycle
    a_accept_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_res.valid)
        else $error("accepted byte produced no result");

    // an end result always closes its run
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == K_END) |-> o_res.last_of_run)
        else $error("end result not flagged last of run");

    // a final byte always hands an end result to the queue
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_byte.last_byte) |-> (push.two && res1.kind == K_END))
        else $error("final byte without end result");

endmodule
